// File: sv/ngsv_pkg.sv
// ----------------------------------------------------------------------------
// ngsv_pkg
// Shared constants, result type and prefix character tables for the NMEA GSV
// sentence parser.
// ----------------------------------------------------------------------------
package ngsv_pkg;

  localparam int LINE_BYTES     = 128;
  localparam int PARSE_WINDOW   = 120;
  localparam int POS_W          = $clog2(LINE_BYTES);
  localparam int CMP_W          = 9;
  localparam int BYTE_W         = 8;
  localparam int FIELD_W        = 7;
  localparam int FIELD_MAX      = 127;
  localparam int VALUE_W        = 10;
  localparam int PROD_W         = 14;
  localparam int VALUE_MAX      = 999;
  localparam int SNR_W          = 7;
  localparam int SNR_LIMIT      = 99;
  localparam int COUNT_W        = 10;
  localparam int TOTAL_W        = 12;
  localparam int KIND_W         = 3;
  localparam int NUM_CON        = 4;
  localparam int PREFIX_N       = 5;
  localparam int GSV_PREFIX_LEN = 6;
  localparam int SPF_PREFIX_LEN = 13;

  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // constellation slots of the in-view counters and prefix match bits
  localparam logic [1:0] CON_GPS = 2'd0;
  localparam logic [1:0] CON_GLO = 2'd1;
  localparam logic [1:0] CON_GAL = 2'd2;
  localparam logic [1:0] CON_GN  = 2'd3;
  localparam int         SPF_BIT = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_OTHER = 3'd0,
    KIND_GPS   = 3'd1,
    KIND_GLO   = 3'd2,
    KIND_GAL   = 3'd3,
    KIND_GN    = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [TOTAL_W-1:0]   sats;
    logic [SNR_W-1:0]     snr_peak;
    logic [SNR_W-1:0]     snr_worst;
    logic                 interference;
  } result_t;

  // "$G?GSV" with the talker letter picked by constellation
  function automatic logic [BYTE_W-1:0] gsv_char(input logic [1:0] con,
                                                 input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      3'd0: c = "$";
      3'd1: c = "G";
      3'd2: begin
        unique case (con)
          CON_GPS: c = "P";
          CON_GLO: c = "L";
          CON_GAL: c = "A";
          CON_GN:  c = "N";
        endcase
      end
      3'd3: c = "G";
      3'd4: c = "S";
      3'd5: c = "V";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "$PMTKSPF,3*58"
  function automatic logic [BYTE_W-1:0] spf_char(input logic [3:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      4'd0:  c = "$";
      4'd1:  c = "P";
      4'd2:  c = "M";
      4'd3:  c = "T";
      4'd4:  c = "K";
      4'd5:  c = "S";
      4'd6:  c = "P";
      4'd7:  c = "F";
      4'd8:  c = ",";
      4'd9:  c = "3";
      4'd10: c = "*";
      4'd11: c = "5";
      4'd12: c = "8";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: sv/ngsv_if.sv
// ----------------------------------------------------------------------------
// ngsv_if
// Valid/ready channels of the GSV parser: received bytes in, line results out.
// ----------------------------------------------------------------------------
interface ngsv_byte_if;
  import ngsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ngsv_result_if;
  import ngsv_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  sentence_kind;
  logic [TOTAL_W-1:0] satellites_in_view;
  logic [SNR_W-1:0]   snr_peak;
  logic [SNR_W-1:0]   snr_worst;
  logic               interference;

  modport source (output valid, output sentence_kind, output satellites_in_view,
                  output snr_peak, output snr_worst, output interference,
                  input ready);
  modport sink   (input valid, input sentence_kind, input satellites_in_view,
                  input snr_peak, input snr_worst, input interference,
                  output ready);
endinterface

// File: sv/ngsv_in_stage.sv
// ----------------------------------------------------------------------------
// ngsv_in_stage
// Input register: holds one received word until the parse stage takes it.
// ----------------------------------------------------------------------------
module ngsv_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ngsv_byte_if.sink                 rx_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [ngsv_pkg::BYTE_W-1:0] byte_o
);
  import ngsv_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              accept;

  assign rx_i.ready = !valid_q || take_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (accept) begin
      valid_d = 1'b1;
      byte_d  = rx_i.rx_byte;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: sv/ngsv_parse_core.sv
// ----------------------------------------------------------------------------
// ngsv_parse_core
// Per-byte line state: prefix matching, field counting, digit accumulation,
// in-view counters and SNR extremes. Emits one result per newline.
// ----------------------------------------------------------------------------
module ngsv_parse_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [ngsv_pkg::BYTE_W-1:0] byte_i,
  output logic                        emit_o,
  output ngsv_pkg::result_t           result_o
);
  import ngsv_pkg::*;

  logic [COUNT_W-1:0]  counts_q [NUM_CON];
  logic [COUNT_W-1:0]  counts_d [NUM_CON];
  logic [COUNT_W-1:0]  counts_cl [NUM_CON];
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [FIELD_W-1:0]  field_q, field_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic                stopped_q, stopped_d;
  logic [PREFIX_N-1:0] prefix_q, prefix_d;
  logic [SNR_W-1:0]    best_q, best_d, best_cl;
  logic [SNR_W-1:0]    worst_q, worst_d, worst_cl;

  logic [CMP_W-1:0]    pos_ext;
  logic                is_lf, is_cr, is_comma, is_digit;
  logic                store, parse, comma_close, close_en;
  kind_e               kind_cur;
  logic [1:0]          con_idx;
  logic [PROD_W-1:0]   prod;
  logic [TOTAL_W-1:0]  total;

  assign pos_ext  = CMP_W'(pos_q);
  assign is_lf    = (byte_i == CHAR_LF);
  assign is_cr    = (byte_i == CHAR_CR);
  assign is_comma = (byte_i == CHAR_COMMA);
  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign store    = !is_lf && !is_cr && (pos_ext < CMP_W'(LINE_BYTES - 1));
  assign parse    = pos_ext < CMP_W'(PARSE_WINDOW - 1);
  assign comma_close = store && parse && is_comma && (field_q < FIELD_W'(FIELD_MAX));
  assign close_en = step_i && (is_lf || comma_close);

  // first matching GSV talker wins
  always_comb begin
    kind_cur = KIND_OTHER;
    if (pos_ext >= CMP_W'(GSV_PREFIX_LEN)) begin
      priority if (prefix_q[CON_GPS]) kind_cur = KIND_GPS;
      else if (prefix_q[CON_GLO])     kind_cur = KIND_GLO;
      else if (prefix_q[CON_GAL])     kind_cur = KIND_GAL;
      else if (prefix_q[CON_GN])      kind_cur = KIND_GN;
      else                            kind_cur = KIND_OTHER;
    end
  end

  assign con_idx = 2'(kind_cur - KIND_GPS);

  // close the open field: counter update on field 3, SNR on 7, 11, 15 ...
  always_comb begin
    counts_cl = counts_q;
    best_cl   = best_q;
    worst_cl  = worst_q;
    if (close_en && kind_cur != KIND_OTHER) begin
      if (field_q == FIELD_W'(3)) begin
        counts_cl[con_idx] = value_q;
      end
      if (field_q >= FIELD_W'(7) && field_q[1:0] == 2'b11 && value_q != '0) begin
        if (value_q < VALUE_W'(SNR_LIMIT) && value_q > VALUE_W'(best_q)) begin
          best_cl = SNR_W'(value_q);
        end
        if (value_q < VALUE_W'(worst_q)) begin
          worst_cl = SNR_W'(value_q);
        end
      end
    end
  end

  assign prod = (PROD_W'(value_q) << 3) + (PROD_W'(value_q) << 1)
              + PROD_W'(byte_i - CHAR_ZERO);

  always_comb begin
    counts_d  = counts_cl;
    best_d    = best_cl;
    worst_d   = worst_cl;
    pos_d     = pos_q;
    field_d   = field_q;
    value_d   = value_q;
    stopped_d = stopped_q;
    prefix_d  = prefix_q;
    if (step_i) begin
      if (is_lf) begin
        // clear line state
        pos_d     = '0;
        field_d   = '0;
        value_d   = '0;
        stopped_d = 1'b0;
        prefix_d  = '1;
        best_d    = '0;
        worst_d   = SNR_W'(SNR_LIMIT);
      end else if (store) begin
        for (int k = 0; k < NUM_CON; k++) begin
          if (pos_ext < CMP_W'(GSV_PREFIX_LEN) && byte_i != gsv_char(2'(k), pos_q[2:0])) begin
            prefix_d[k] = 1'b0;
          end
        end
        if (pos_ext < CMP_W'(SPF_PREFIX_LEN) && byte_i != spf_char(pos_q[3:0])) begin
          prefix_d[SPF_BIT] = 1'b0;
        end
        if (parse) begin
          priority if (comma_close) begin
            field_d   = field_q + FIELD_W'(1);
            value_d   = '0;
            stopped_d = 1'b0;
          end else if (!stopped_q && is_digit) begin
            value_d = (prod > PROD_W'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : VALUE_W'(prod);
          end else begin
            stopped_d = 1'b1;
          end
        end
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  assign total = (counts_cl[CON_GN] != '0) ? TOTAL_W'(counts_cl[CON_GN])
               : TOTAL_W'(counts_cl[CON_GPS]) + TOTAL_W'(counts_cl[CON_GLO])
                 + TOTAL_W'(counts_cl[CON_GAL]);

  assign emit_o = step_i && is_lf;

  always_comb begin
    result_o.kind         = kind_cur;
    result_o.sats         = total;
    result_o.snr_peak     = (kind_cur != KIND_OTHER) ? best_cl : '0;
    result_o.snr_worst    = (kind_cur != KIND_OTHER) ? worst_cl : SNR_W'(SNR_LIMIT);
    result_o.interference = prefix_q[SPF_BIT] && (pos_ext >= CMP_W'(SPF_PREFIX_LEN));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CON; k++) begin
        counts_q[k] <= '0;
      end
      pos_q     <= '0;
      field_q   <= '0;
      value_q   <= '0;
      stopped_q <= 1'b0;
      prefix_q  <= '1;
      best_q    <= '0;
      worst_q   <= SNR_W'(SNR_LIMIT);
    end else begin
      counts_q  <= counts_d;
      pos_q     <= pos_d;
      field_q   <= field_d;
      value_q   <= value_d;
      stopped_q <= stopped_d;
      prefix_q  <= prefix_d;
      best_q    <= best_d;
      worst_q   <= worst_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) best_q < SNR_W'(SNR_LIMIT))
    else $error("best SNR reached the limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni) worst_q != '0)
    else $error("worst SNR went to zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni) value_q <= VALUE_W'(VALUE_MAX))
    else $error("field value not saturated");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   emit_o |=> (pos_q == '0 && field_q == '0 && prefix_q == '1))
    else $error("line state not cleared after newline");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_i && is_cr) |=> $stable(pos_q) && $stable(field_q))
    else $error("carriage return disturbed line state");
`endif

endmodule

// File: sv/nmea_gsv_satellite_parser.sv
// ----------------------------------------------------------------------------
// nmea_gsv_satellite_parser
// NMEA 0183 GSV sentence parser: one received character per word in, one
// summary word out for every line.
// ----------------------------------------------------------------------------
// Channels: rx_i carries one character per word; res_o carries one word per
// newline with sentence kind, satellites in view, best and worst SNR and the
// interference notice flag. Carriage returns and other characters give no
// word on res_o.
// Path: an accepted character waits in the input register until parsed; a
// newline's result is registered in the output register and shown on res_o.
// Throughput: one character per cycle while no newline is held back, set by
// the single parse stage that updates all line state from the input register.
// Reset: clears the in-view counters and all line state; no word is held.
// Stall: a result waits in the output register while res_o.ready is low.
// Ordinary characters keep flowing; a newline waits in the input register
// until the output register frees, and rx_i.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module nmea_gsv_satellite_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  ngsv_byte_if.sink     rx_i,
  ngsv_result_if.source res_o
);
  import ngsv_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;
  logic              emit;
  result_t           result;

  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  // hold a newline while the previous result is still unread
  assign advance = s1_valid && ((s1_byte != CHAR_LF) || !out_valid_q || res_o.ready);

  ngsv_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (advance),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  ngsv_parse_core u_parse_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (s1_byte),
    .emit_o   (emit),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.sentence_kind      = out_q.kind;
  assign res_o.satellites_in_view = out_q.sats;
  assign res_o.snr_peak           = out_q.snr_peak;
  assign res_o.snr_worst          = out_q.snr_worst;
  assign res_o.interference       = out_q.interference;

endmodule

// File: bench/tb_nmea_gsv_satellite_parser.sv
// ----------------------------------------------------------------------------
// tb_nmea_gsv_satellite_parser
// Feeds NMEA character streams into the GSV parser and checks every line
// summary. A table of hand-written lines comes first: edge cases with their
// summaries typed in, the rest predicted. Random sentences, broken lines and
// byte noise follow, all checked against a line-state model kept here. Both
// sides idle in random bursts, and the summary side holds off once for a
// long stretch so that a newline backs up into the character channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nmea_gsv_satellite_parser;
  import ngsv_pkg::*;

  localparam int  CLK_PERIOD   = 10;
  localparam int  TIMEOUT_NS   = 4_000_000;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  TAIL_CHARS   = 300;
  localparam int  TOTAL_CHARS  = 1100;
  localparam int  FIELD_COUNT  = 3;
  localparam int  FIELD_SNR0   = 7;
  localparam logic [BYTE_W-1:0] NUL_MARK = "^";

  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                typed;
    result_t           want;
  } stim_t;

  typedef struct {
    string             text;
    logic [BYTE_W-1:0] fill_ch;
    int                fill_n;
    bit                typed;
    kind_e             kind;
    int                sats;
    int                best;
    int                worst;
    bit                intf;
  } line_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_long = 1'b0;

  ngsv_byte_if   rx_if ();
  ngsv_result_if res_if ();

  nmea_gsv_satellite_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // a caret in a row stands for a NUL byte
  line_row_t dir_rows [22] = '{
    '{"", " ", 0, 1'b1, KIND_OTHER, 0, 0, 99, 1'b0},
    '{"$PMTKSPF,3*58", " ", 0, 1'b1, KIND_OTHER, 0, 0, 99, 1'b1},
    '{"$PMTKSPF,3*5", " ", 0, 1'b1, KIND_OTHER, 0, 0, 99, 1'b0},
    '{"$GPGSV", " ", 0, 1'b1, KIND_GPS, 0, 0, 99, 1'b0},
    '{"$GPGS", " ", 0, 1'b1, KIND_OTHER, 0, 0, 99, 1'b0},
    '{"$GPGSV,3,1,11,01,45,083,32,02,20,150,,03,60,270,47,04,05,010,12", " ", 0, 1'b1,
      KIND_GPS, 11, 47, 12, 1'b0},
    '{"$GLGSV,2,1,07,65,30,100,99,66,10,200,98*7A", " ", 0, 1'b1,
      KIND_GLO, 18, 98, 98, 1'b0},
    '{"$GAGSV,1,1,1234,,,,0", " ", 0, 1'b1, KIND_GAL, 1017, 0, 99, 1'b0},
    '{"$GNGSV,1,1,00", " ", 0, 1'b1, KIND_GN, 1017, 0, 99, 1'b0},
    '{"$GNGSV,1,1,25,01,50,100,01", " ", 0, 1'b1, KIND_GN, 25, 1, 1, 1'b0},
    '{"$GNGSV,1,1", " ", 0, 1'b1, KIND_GN, 25, 0, 99, 1'b0},
    '{"$gpgsv,1,1,05", " ", 0, 1'b1, KIND_OTHER, 25, 0, 99, 1'b0},
    '{"$GPGSV,1,1, 5,01,02,003,-4", " ", 0, 1'b1, KIND_GPS, 25, 0, 99, 1'b0},
    '{"$GPGSV,1,1,\r0\r9,01,02,003,5\r", " ", 0, 1'b1, KIND_GPS, 25, 5, 5, 1'b0},
    '{"$GNGSV,1,1,0^,x", " ", 0, 1'b1, KIND_GN, 1015, 0, 99, 1'b0},
    '{"\377$GPGSV,1,1,3", " ", 0, 1'b1, KIND_OTHER, 1015, 0, 99, 1'b0},
    '{"$PMTKSPF,3*58,more", " ", 0, 1'b1, KIND_OTHER, 1015, 0, 99, 1'b1},
    '{"$GPGSV,2,1,08,01,40,083,4", "7", 100, 1'b0, KIND_OTHER, 0, 0, 0, 1'b0},
    '{"$GNGSV,1,1,0", ",", 130, 1'b0, KIND_OTHER, 0, 0, 0, 1'b0},
    '{"$GLGSV,1,1,5", "A", 200, 1'b0, KIND_OTHER, 0, 0, 0, 1'b0},
    '{"$GAGSV,1,1,2,10,20,30,98,11,21,31,1,12,22,32,99,13,23,33,100", " ", 0, 1'b0,
      KIND_OTHER, 0, 0, 0, 1'b0},
    '{"\r", " ", 0, 1'b0, KIND_OTHER, 0, 0, 0, 1'b0}
  };

  stim_t   char_q [$];
  result_t summary_q [$];

  int send_idx = 0;
  int send_gap = 0;
  int stall_left = 0;
  int tail_start = 0;
  int press_at = 0;
  int mismatches = 0;

  // line state of the parser as predicted here
  logic [COUNT_W-1:0]  con_count [NUM_CON];
  logic [6:0]          line_len;
  logic [FIELD_W-1:0]  field_idx;
  logic [VALUE_W-1:0]  field_val;
  logic                digits_done;
  logic [PREFIX_N-1:0] prefix_ok;
  logic [SNR_W-1:0]    snr_hi;
  logic [SNR_W-1:0]    snr_lo;

  string gsv_tag [NUM_CON] = '{"$GPGSV", "$GLGSV", "$GAGSV", "$GNGSV"};
  string spf_tag = "$PMTKSPF,3*58";

  function automatic void start_line();
    line_len    = '0;
    field_idx   = '0;
    field_val   = '0;
    digits_done = 1'b0;
    prefix_ok   = '1;
    snr_hi      = '0;
    snr_lo      = SNR_W'(SNR_LIMIT);
  endfunction

  function automatic kind_e gsv_kind();
    int n;
    if (line_len < GSV_PREFIX_LEN) return KIND_OTHER;
    for (n = 0; n < NUM_CON; n++)
      if (prefix_ok[n]) return kind_e'(n + 1);
    return KIND_OTHER;
  endfunction

  function automatic void end_field();
    kind_e k;
    k = gsv_kind();
    if (k == KIND_OTHER) return;
    if (field_idx == FIELD_COUNT) con_count[int'(k) - 1] = field_val;
    // SNR sits in every fourth field from the first satellite block on
    if (field_idx >= FIELD_SNR0 && field_idx[1:0] == 2'd3 && field_val != 0) begin
      if (field_val < SNR_LIMIT && field_val > snr_hi) snr_hi = field_val[SNR_W-1:0];
      if (field_val < snr_lo) snr_lo = field_val[SNR_W-1:0];
    end
  endfunction

  // advance the line state by one character; return 1 with a summary on newline
  function automatic bit parse_char(input logic [BYTE_W-1:0] b, output result_t r);
    kind_e k;
    int    n;
    int    pos;
    int    v;
    string tag;
    r = '0;
    if (b == CHAR_LF) begin
      end_field();
      k = gsv_kind();
      r.kind = k;
      if (con_count[CON_GN] != 0) r.sats = TOTAL_W'(con_count[CON_GN]);
      else r.sats = TOTAL_W'(con_count[CON_GPS]) + TOTAL_W'(con_count[CON_GLO])
                    + TOTAL_W'(con_count[CON_GAL]);
      r.snr_peak     = (k != KIND_OTHER) ? snr_hi : '0;
      r.snr_worst    = (k != KIND_OTHER) ? snr_lo : SNR_W'(SNR_LIMIT);
      r.interference = prefix_ok[SPF_BIT] && line_len >= SPF_PREFIX_LEN;
      start_line();
      return 1'b1;
    end
    if (b == CHAR_CR || line_len >= LINE_BYTES - 1) return 1'b0;
    pos = line_len;
    for (n = 0; n < NUM_CON; n++) begin
      tag = gsv_tag[n];
      if (pos < GSV_PREFIX_LEN && b != tag[pos]) prefix_ok[n] = 1'b0;
    end
    if (pos < SPF_PREFIX_LEN && b != spf_tag[pos]) prefix_ok[SPF_BIT] = 1'b0;
    if (pos < PARSE_WINDOW - 1) begin
      if (b == CHAR_COMMA && field_idx < FIELD_MAX) begin
        end_field();
        field_idx++;
        field_val   = '0;
        digits_done = 1'b0;
      end else if (!digits_done && b >= CHAR_ZERO && b <= CHAR_NINE) begin
        v = field_val * 10 + (b - CHAR_ZERO);
        field_val = VALUE_W'((v > VALUE_MAX) ? VALUE_MAX : v);
      end else begin
        digits_done = 1'b1;
      end
    end
    line_len++;
    return 1'b0;
  endfunction

  function automatic void push_char(logic [BYTE_W-1:0] b);
    stim_t item;
    item.b     = b;
    item.typed = 1'b0;
    item.want  = '0;
    char_q.push_back(item);
  endfunction

  function automatic void push_text(string s, int cr_pct);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if ($urandom_range(0, 99) < cr_pct) push_char(CHAR_CR);
      push_char((s[i] == NUL_MARK) ? 8'h00 : s[i]);
    end
  endfunction

  function automatic void end_line(bit typed, result_t want);
    push_char(CHAR_LF);
    char_q[$].typed = typed;
    char_q[$].want  = want;
  endfunction

  // numeric field text, now and then empty, signed, padded or led by a space
  function automatic string num_text(int lo, int hi);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return "";
    if (pick == 1) return $sformatf("-%0d", $urandom_range(hi, lo));
    if (pick == 2) return $sformatf(" %0d", $urandom_range(hi, lo));
    if (pick < 6) return $sformatf("%02d", $urandom_range(hi, lo));
    return $sformatf("%0d", $urandom_range(hi, lo));
  endfunction

  function automatic void add_random_line();
    string s;
    string letters;
    string digs;
    int    pick;
    int    nsat;
    int    i;
    int    n;
    logic [BYTE_W-1:0] b;
    letters = "PLANB";
    digs    = ",,0123456789";
    pick    = $urandom_range(0, 99);
    if (pick < 70) begin
      s = $sformatf("$G%cGSV,%0d,%0d,%s", letters[$urandom_range(0, 4)],
                    $urandom_range(1, 4), $urandom_range(1, 4),
                    ($urandom_range(0, 19) == 0) ? num_text(900, 1500) : num_text(0, 40));
      nsat = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
      for (i = 0; i < nsat; i++)
        s = {s, ",", num_text(1, 99), ",", num_text(0, 90), ",", num_text(0, 359), ",",
             num_text(0, 120)};
      if ($urandom_range(0, 1)) s = {s, $sformatf("*%02X", $urandom_range(0, 255))};
      if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
      push_text(s, 4);
    end else if (pick < 80) begin
      s = spf_tag;
      if ($urandom_range(0, 1)) s.putc($urandom_range(0, 12), 8'($urandom_range(33, 126)));
      if ($urandom_range(0, 3) == 0) s = s.substr(0, $urandom_range(0, 11));
      if ($urandom_range(0, 2) == 0) s = {s, ",1,2"};
      push_text(s, 4);
    end else if (pick < 95) begin
      n = $urandom_range(0, 40);
      repeat (n) begin
        do b = BYTE_W'($urandom_range(0, 255)); while (b == CHAR_LF);
        push_char(b);
      end
    end else begin
      s = $sformatf("$G%cGSV", letters[$urandom_range(0, 4)]);
      n = $urandom_range(100, 250);
      repeat (n) begin
        i = $urandom_range(0, 11);
        s = {s, digs.substr(i, i)};
      end
      push_text(s, 0);
    end
  endfunction

  function automatic bit idle_ok();
    return send_idx < tail_start && (send_idx / 256) % 3 != 2;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // character side: predict on each accepted word, then offer the next
  always @(posedge clk_i) begin : feed
    result_t line_sum;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        if (parse_char(char_q[send_idx].b, line_sum))
          summary_q.push_back(char_q[send_idx].typed ? char_q[send_idx].want : line_sum);
        send_idx++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          rx_if.valid <= 1'b0;
        end else if (send_idx < char_q.size()) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= char_q[send_idx].b;
          if (idle_ok() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // summary side: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin : drain
    result_t due;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (summary_q.size() == 0) begin
          $display("%0t ns: unexpected summary word: kind %0d, sats %0d", $time,
                   res_if.sentence_kind, res_if.satellites_in_view);
          mismatches++;
        end else begin
          due = summary_q.pop_front();
          check_field("sentence_kind", int'(due.kind), res_if.sentence_kind);
          check_field("satellites_in_view", due.sats, res_if.satellites_in_view);
          check_field("snr_peak", due.snr_peak, res_if.snr_peak);
          check_field("snr_worst", due.snr_worst, res_if.snr_worst);
          check_field("interference", due.interference, res_if.interference);
        end
      end
      if (hold_long) begin
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (idle_ok() && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // hold off the summary side long enough for a newline to back up
  initial begin : long_hold
    int cycles;
    wait (rst_ni === 1'b1);
    while (send_idx < press_at) @(posedge clk_i);
    hold_long <= 1'b1;
    for (cycles = 0; cycles < HOLD_CYCLES; cycles++) @(posedge clk_i);
    hold_long <= 1'b0;
  end

  initial begin : run
    result_t row_sum;
    int      random_start;
    int      k;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    for (k = 0; k < NUM_CON; k++) con_count[k] = '0;
    start_line();

    foreach (dir_rows[i]) begin
      push_text(dir_rows[i].text, 0);
      repeat (dir_rows[i].fill_n) push_char(dir_rows[i].fill_ch);
      row_sum.kind         = dir_rows[i].kind;
      row_sum.sats         = TOTAL_W'(dir_rows[i].sats);
      row_sum.snr_peak     = SNR_W'(dir_rows[i].best);
      row_sum.snr_worst    = SNR_W'(dir_rows[i].worst);
      row_sum.interference = dir_rows[i].intf;
      end_line(dir_rows[i].typed, row_sum);
    end

    random_start = char_q.size();
    while (char_q.size() < TOTAL_CHARS) begin
      add_random_line();
      end_line(1'b0, '0);
    end
    tail_start = char_q.size() - TAIL_CHARS;
    press_at   = random_start / 2;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (send_idx < char_q.size() || summary_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
